// ===== rtl/complementary_attitude_filter_macros.svh =====
// ----------------------------------------------------------------------------
// complementary attitude filter assertion macros
// shared property shapes for the filter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_MACROS_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_MACROS_SVH

// same-cycle implication
`define CAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/caf_pkg.sv =====
// ----------------------------------------------------------------------------
// caf_pkg
// shared constants, types and the arctangent step table of the attitude filter
// ----------------------------------------------------------------------------
package caf_pkg;

    localparam int CAF_DW        = 64;
    localparam int CAF_CW        = 44;
    localparam int CAF_ZW        = 36;
    localparam int CAF_OW        = 25;
    localparam int CAF_TW        = 14;
    localparam int CAF_SW        = 16;
    localparam int CAF_ACC_SH    = 24;
    localparam int CAF_FRAC_DEF  = 16;
    localparam int CAF_STEPS_DEF = 20;

    localparam logic [CAF_TW-1:0]        CAF_TC_RESET = 14'd100;
    localparam logic [CAF_DW-1:0]        CAF_DEG_Q24  = 64'd961263677;
    localparam logic [CAF_DW-1:0]        CAF_GYRO_DIV = 64'd16000;
    localparam logic [CAF_DW-1:0]        CAF_GYRO_RND = 64'd8000;
    localparam logic signed [CAF_ZW-1:0] CAF_QUAD     = 36'sd1686629713;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    // atan(2^-i) in q30 radians
    function automatic logic signed [CAF_ZW-1:0] caf_atan_step(input logic [4:0] idx);
        logic signed [CAF_ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 36'sd843314856;
            5'd1:    v = 36'sd497837829;
            5'd2:    v = 36'sd263043836;
            5'd3:    v = 36'sd133525158;
            5'd4:    v = 36'sd67021686;
            5'd5:    v = 36'sd33543515;
            5'd6:    v = 36'sd16775850;
            5'd7:    v = 36'sd8388437;
            5'd8:    v = 36'sd4194282;
            5'd9:    v = 36'sd2097149;
            5'd31:   v = '0;
            default: v = signed'(CAF_ZW'(64'd1 << (30 - int'(idx))));
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/caf_mdu.sv =====
// ----------------------------------------------------------------------------
// caf_mdu
// bit-serial unsigned multiply and restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
module caf_mdu (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  caf_pkg::t_mdu_req           i_req,
    input  logic [caf_pkg::CAF_DW-1:0]  i_a,
    input  logic [caf_pkg::CAF_DW-1:0]  i_b,
    output logic                        o_done,
    output logic [caf_pkg::CAF_DW-1:0]  o_res,
    output logic [caf_pkg::CAF_DW-1:0]  o_rem
);
    import caf_pkg::*;

    localparam int W   = CAF_DW;
    localparam int CNW = $clog2(CAF_DW);

    logic           r_busy;
    logic           r_done;
    t_mdu_op        r_op;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_a;
    logic [W-1:0]   r_b;
    logic [CNW-1:0] r_cnt;

    logic [W:0]     w_trial;
    logic [W:0]     w_diff;
    logic           w_ge;

    assign w_trial = {r_acc, r_a[W-1]};
    assign w_diff  = w_trial - {1'b0, r_b};
    assign w_ge    = (w_trial >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= CNW'(W - 1);
            end else if (r_busy) begin
                unique case (r_op)
                    MDU_MUL: begin
                        if (r_b == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            if (r_b[0]) begin
                                r_acc <= r_acc + r_a;
                            end
                            r_a <= {r_a[W-2:0], 1'b0};
                            r_b <= {1'b0, r_b[W-1:1]};
                        end
                    end
                    MDU_DIV: begin
                        r_acc <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
                        r_a   <= {r_a[W-2:0], w_ge};
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == MDU_MUL) ? r_acc : r_a;
    assign o_rem  = r_acc;

endmodule

// ===== rtl/complementary_attitude_filter.sv =====
// ----------------------------------------------------------------------------
// complementary_attitude_filter
// roll, pitch and yaw from one imu word per step, accel tilt blended with gyro
//
// One word is worked on at a time. After acceptance the block forms the squared
// accel sum, takes its square root, and for each of the two arctangents runs
// CORDIC_STEPS vectoring steps (20 by default) plus a serial multiply by a
// 30-bit constant for the degree scale. Three gyro increments and two blend
// divides each take a pass of the shared bit-serial multiply/divide unit, as do
// the blend multiplies by the 14-bit time constant, and an angle that leaves
// +-180 degrees costs one more divide; that unit sets the pace.
// A finished result sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`include "complementary_attitude_filter_macros.svh"

module complementary_attitude_filter #(
    parameter int ANGLE_FRAC_BITS = caf_pkg::CAF_FRAC_DEF,
    parameter int CORDIC_STEPS    = caf_pkg::CAF_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [caf_pkg::CAF_TW-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [caf_pkg::CAF_SW-1:0] i_accel_x,
    input  logic signed [caf_pkg::CAF_SW-1:0] i_accel_y,
    input  logic signed [caf_pkg::CAF_SW-1:0] i_accel_z,
    input  logic signed [caf_pkg::CAF_SW-1:0] i_rate_x,
    input  logic signed [caf_pkg::CAF_SW-1:0] i_rate_y,
    input  logic signed [caf_pkg::CAF_SW-1:0] i_rate_z,
    input  logic [caf_pkg::CAF_SW-1:0]        i_elapsed_ms,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [caf_pkg::CAF_OW-1:0] o_roll_deg,
    output logic signed [caf_pkg::CAF_OW-1:0] o_pitch_deg,
    output logic signed [caf_pkg::CAF_OW-1:0] o_yaw_deg
);
    import caf_pkg::*;

    localparam int W      = CAF_DW;
    localparam int CW     = CAF_CW;
    localparam int ZW     = CAF_ZW;
    localparam int SW     = ANGLE_FRAC_BITS + 10;
    localparam int GW     = ANGLE_FRAC_BITS + 19;
    localparam int IW     = $clog2(CORDIC_STEPS);
    localparam int SRW    = 35;
    localparam int DEG_SH = 54 - ANGLE_FRAC_BITS;

    localparam logic signed [W-1:0] DEG_RND = W'(1) << (DEG_SH - 1);
    localparam logic signed [W-1:0] HALF    = W'(180) << ANGLE_FRAC_BITS;
    localparam logic signed [W-1:0] FULL    = W'(360) << ANGLE_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_CINIT, S_CITER, S_DEG, S_DEGW, S_GD,
        S_GDW, S_BMUL, S_BMULW, S_BDIVW, S_WRAP, S_WRAPW, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        AX_PITCH, AX_ROLL, AX_YAW
    } t_axis;

    typedef enum logic [1:0] {
        WR_PASS, WR_ABOVE, WR_BELOW
    } t_wrap;

    t_state                 r_state;
    t_axis                  r_k;
    t_wrap                  r_wmode;
    logic [CAF_TW-1:0]      r_tc;
    logic signed [15:0]     r_ax, r_ay, r_az, r_gx, r_gy, r_gz;
    logic [15:0]            r_e;
    logic [63:0]            r_rad;
    logic [31:0]            r_root;
    logic [SRW-1:0]         r_srem;
    logic [4:0]             r_scnt;
    logic signed [CW-1:0]   r_cx, r_cy;
    logic signed [ZW-1:0]   r_cz;
    logic [IW-1:0]          r_ci;
    logic                   r_czero;
    logic signed [SW-1:0]   r_acc_p, r_acc_r;
    logic signed [SW-1:0]   r_pitch, r_roll, r_yaw;
    logic signed [GW-1:0]   r_gd_p, r_gd_r, r_gd_y;
    logic signed [W-1:0]    r_x;
    logic                   r_neg;
    t_mdu_req               r_req;
    logic [W-1:0]           r_ma, r_mb;
    logic                   r_o_valid;
    logic signed [CAF_OW-1:0] r_o_roll, r_o_pitch, r_o_yaw;

    logic                   w_done;
    logic [W-1:0]           w_res, w_rem;
    logic signed [W-1:0]    w_res_s;
    logic signed [31:0]     w_ay2, w_az2;
    logic [31:0]            w_sq;
    logic [SRW-1:0]         w_strem, w_strial;
    logic                   w_sge;
    logic signed [CW-1:0]   w_x0, w_y0, n_cx, n_cy;
    logic signed [ZW-1:0]   n_cz;
    logic                   w_czero;
    logic signed [CW-1:0]   w_dx, w_dy;
    logic signed [ZW-1:0]   w_step;
    logic [W-1:0]           w_zmag;
    logic signed [W-1:0]    w_deg;
    logic signed [15:0]     w_rate;
    logic signed [32:0]     w_re;
    logic [31:0]            w_re_mag;
    logic [W-1:0]           w_gd_num;
    logic signed [SW-1:0]   w_old, w_acc;
    logic signed [GW-1:0]   w_gd;
    logic signed [W-1:0]    w_bsum, w_bnum;
    logic [W-1:0]           w_bsum_mag, w_bdiv_a;
    logic [16:0]            w_te;
    logic signed [SW+16:0]  w_eacc;
    logic signed [W-1:0]    w_rem_s, w_wval;

    caf_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_rem   (w_rem)
    );

    assign w_res_s = r_neg ? -signed'(w_res) : signed'(w_res);

    // square root of the y/z accel magnitude, two radicand bits a cycle
    assign w_ay2    = r_ay * r_ay;
    assign w_az2    = r_az * r_az;
    assign w_sq     = unsigned'(w_ay2) + unsigned'(w_az2);
    assign w_strem  = {r_srem[SRW-3:0], r_rad[63:62]};
    assign w_strial = {1'b0, r_root, 2'b01};
    assign w_sge    = (w_strem >= w_strial);

    // vectoring start with quadrant fold
    always_comb begin
        if (r_k == AX_PITCH) begin
            w_y0 = CW'(r_ay) <<< CAF_ACC_SH;
            w_x0 = CW'(r_az) <<< CAF_ACC_SH;
        end else begin
            w_y0 = -(CW'(r_ax) <<< CAF_ACC_SH);
            w_x0 = signed'({{(CW - 40){1'b0}}, r_root, 8'd0});
        end
        w_czero = (w_x0 == '0) && (w_y0 == '0);
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                n_cx = w_y0;
                n_cy = -w_x0;
                n_cz = CAF_QUAD;
            end else begin
                n_cx = -w_y0;
                n_cy = w_x0;
                n_cz = -CAF_QUAD;
            end
        end else begin
            n_cx = w_x0;
            n_cy = w_y0;
            n_cz = '0;
        end
    end

    assign w_dx   = r_cy >>> r_ci;
    assign w_dy   = r_cx >>> r_ci;
    assign w_step = caf_atan_step(5'(r_ci));
    assign w_zmag = W'((r_cz < 0) ? -r_cz : r_cz);
    assign w_deg  = (w_res_s + DEG_RND) >>> DEG_SH;

    always_comb begin
        case (r_k)
            AX_PITCH: w_rate = r_gx;
            AX_ROLL:  w_rate = r_gy;
            default:  w_rate = r_gz;
        endcase
    end

    assign w_re     = w_rate * $signed({1'b0, r_e});
    assign w_re_mag = 32'((w_re < 0) ? -w_re : w_re);
    assign w_gd_num = (W'(w_re_mag) << ANGLE_FRAC_BITS) + CAF_GYRO_RND;

    always_comb begin
        case (r_k)
            AX_ROLL: begin
                w_old = r_roll;
                w_gd  = r_gd_r;
                w_acc = r_acc_r;
            end
            default: begin
                w_old = r_pitch;
                w_gd  = r_gd_p;
                w_acc = r_acc_p;
            end
        endcase
    end

    assign w_te       = {3'b000, r_tc} + {1'b0, r_e};
    assign w_bsum     = W'(w_old) + W'(w_gd);
    assign w_bsum_mag = (w_bsum < 0) ? -w_bsum : w_bsum;
    assign w_eacc     = $signed({1'b0, r_e}) * w_acc;
    assign w_bnum     = w_res_s + W'(w_eacc);
    assign w_bdiv_a   = ((w_bnum < 0) ? -w_bnum : w_bnum) + W'(w_te >> 1);

    assign w_rem_s = signed'(w_rem);
    always_comb begin
        unique case (r_wmode)
            WR_PASS:  w_wval = r_x;
            WR_ABOVE: w_wval = -HALF + 1 + w_rem_s;
            WR_BELOW: w_wval = (w_rem == '0) ? -HALF : FULL - HALF - w_rem_s;
            default:  w_wval = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= CAF_TC_RESET;
        end else if (i_cfg_we) begin
            r_tc <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= AX_PITCH;
            r_req     <= '{start: 1'b0, op: MDU_MUL};
            r_o_valid <= 1'b0;
            r_pitch   <= '0;
            r_roll    <= '0;
            r_yaw     <= '0;
        end else begin
            r_req.start <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ax    <= i_accel_x;
                        r_ay    <= i_accel_y;
                        r_az    <= i_accel_z;
                        r_gx    <= i_rate_x;
                        r_gy    <= i_rate_y;
                        r_gz    <= i_rate_z;
                        r_e     <= i_elapsed_ms;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_rad   <= {w_sq, 32'd0};
                    r_root  <= '0;
                    r_srem  <= '0;
                    r_scnt  <= 5'd31;
                    r_k     <= AX_PITCH;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_srem <= w_sge ? (w_strem - w_strial) : w_strem;
                    r_root <= {r_root[30:0], w_sge};
                    r_rad  <= {r_rad[61:0], 2'b00};
                    r_scnt <= r_scnt - 1'b1;
                    if (r_scnt == '0) begin
                        r_state <= S_CINIT;
                    end
                end
                S_CINIT: begin
                    r_cx    <= n_cx;
                    r_cy    <= n_cy;
                    r_cz    <= n_cz;
                    r_czero <= w_czero;
                    r_ci    <= '0;
                    r_state <= S_CITER;
                end
                S_CITER: begin
                    if (!r_cy[CW-1]) begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + w_step;
                    end else begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - w_step;
                    end
                    if (r_ci == IW'(CORDIC_STEPS - 1)) begin
                        r_state <= S_DEG;
                    end else begin
                        r_ci <= r_ci + 1'b1;
                    end
                end
                S_DEG: begin
                    if (r_czero) begin
                        if (r_k == AX_PITCH) begin
                            r_acc_p <= '0;
                            r_k     <= AX_ROLL;
                            r_state <= S_CINIT;
                        end else begin
                            r_acc_r <= '0;
                            r_k     <= AX_PITCH;
                            r_state <= S_GD;
                        end
                    end else begin
                        r_neg   <= (r_cz < 0);
                        r_ma    <= w_zmag;
                        r_mb    <= CAF_DEG_Q24;
                        r_req   <= '{start: 1'b1, op: MDU_MUL};
                        r_state <= S_DEGW;
                    end
                end
                S_DEGW: begin
                    if (w_done) begin
                        if (r_k == AX_PITCH) begin
                            r_acc_p <= SW'(w_deg);
                            r_k     <= AX_ROLL;
                            r_state <= S_CINIT;
                        end else begin
                            r_acc_r <= SW'(w_deg);
                            r_k     <= AX_PITCH;
                            r_state <= S_GD;
                        end
                    end
                end
                S_GD: begin
                    r_neg   <= (w_re < 0);
                    r_ma    <= w_gd_num;
                    r_mb    <= CAF_GYRO_DIV;
                    r_req   <= '{start: 1'b1, op: MDU_DIV};
                    r_state <= S_GDW;
                end
                S_GDW: begin
                    if (w_done) begin
                        case (r_k)
                            AX_PITCH: begin
                                r_gd_p  <= GW'(w_res_s);
                                r_k     <= AX_ROLL;
                                r_state <= S_GD;
                            end
                            AX_ROLL: begin
                                r_gd_r  <= GW'(w_res_s);
                                r_k     <= AX_YAW;
                                r_state <= S_GD;
                            end
                            default: begin
                                r_gd_y  <= GW'(w_res_s);
                                r_k     <= AX_PITCH;
                                r_state <= S_BMUL;
                            end
                        endcase
                    end
                end
                S_BMUL: begin
                    if (w_te == '0) begin
                        r_x     <= -w_bsum;
                        r_state <= S_WRAP;
                    end else begin
                        r_neg   <= (w_bsum < 0);
                        r_ma    <= w_bsum_mag;
                        r_mb    <= W'(r_tc);
                        r_req   <= '{start: 1'b1, op: MDU_MUL};
                        r_state <= S_BMULW;
                    end
                end
                S_BMULW: begin
                    if (w_done) begin
                        r_neg   <= (w_bnum < 0);
                        r_ma    <= w_bdiv_a;
                        r_mb    <= W'(w_te);
                        r_req   <= '{start: 1'b1, op: MDU_DIV};
                        r_state <= S_BDIVW;
                    end
                end
                S_BDIVW: begin
                    if (w_done) begin
                        r_x     <= -w_res_s;
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (r_x > HALF) begin
                        r_wmode <= WR_ABOVE;
                        r_ma    <= r_x + HALF - 1;
                        r_mb    <= FULL;
                        r_req   <= '{start: 1'b1, op: MDU_DIV};
                    end else if (r_x < -HALF) begin
                        r_wmode <= WR_BELOW;
                        r_ma    <= -r_x - HALF;
                        r_mb    <= FULL;
                        r_req   <= '{start: 1'b1, op: MDU_DIV};
                    end else begin
                        r_wmode <= WR_PASS;
                    end
                    r_state <= S_WRAPW;
                end
                S_WRAPW: begin
                    if (r_wmode == WR_PASS || w_done) begin
                        case (r_k)
                            AX_PITCH: begin
                                r_pitch <= SW'(w_wval);
                                r_k     <= AX_ROLL;
                                r_state <= S_BMUL;
                            end
                            AX_ROLL: begin
                                r_roll  <= SW'(w_wval);
                                r_k     <= AX_YAW;
                                r_x     <= W'(r_yaw) + W'(r_gd_y);
                                r_state <= S_WRAP;
                            end
                            default: begin
                                r_yaw   <= SW'(w_wval);
                                r_k     <= AX_PITCH;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_roll  <= CAF_OW'(r_roll);
                        r_o_pitch <= CAF_OW'(r_pitch);
                        r_o_yaw   <= CAF_OW'(r_yaw);
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_roll_deg  = r_o_roll;
    assign o_pitch_deg = r_o_pitch;
    assign o_yaw_deg   = r_o_yaw;

    `CAF_ASSERT_IMP(a_state_range, i_clk, i_rst_n, 1'b1,
        (r_pitch <= HALF) && (r_pitch >= -HALF) && (r_roll <= HALF) &&
        (r_roll >= -HALF) && (r_yaw <= HALF) && (r_yaw >= -HALF),
        "angle state outside +-180 degrees")
    `CAF_ASSERT_IMP(a_done_waited, i_clk, i_rst_n, w_done,
        (r_state == S_DEGW) || (r_state == S_GDW) || (r_state == S_BMULW) ||
        (r_state == S_BDIVW) || (r_state == S_WRAPW),
        "arithmetic unit finished with no step waiting")
    `CAF_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready,
        "second word taken while one is in work")

endmodule
